[rtl/lkhc_pkg.sv]
// Package with the shared constants and control types of the LRU keyed handle cache.
`default_nettype none
package lkhc_pkg;

    localparam int EVICT_LIMIT_DEF = 20;

    localparam int CMD_W    = 2;
    localparam int DIM_W    = 16;
    localparam int BITS_W   = 64;
    localparam int HANDLE_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic load;
        logic cmp;
        logic exec;
        logic clr_load;
        logic clr_shift;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_clear;
        logic occ_zero;
        logic occ_one;
    } ctrl_stat_t;

endpackage
`default_nettype wire

[rtl/lkhc_ctrl.sv]
// Controller state machine that sequences compare, update and result delivery.
`default_nettype none
module lkhc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire lkhc_pkg::ctrl_stat_t stat,
    output lkhc_pkg::ctrl_cmd_t      cmd
);
    import lkhc_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CMP      = 3'd1;
    localparam logic [2:0] ST_EXEC     = 3'd2;
    localparam logic [2:0] ST_OUT      = 3'd3;
    localparam logic [2:0] ST_CLR_LOAD = 3'd4;
    localparam logic [2:0] ST_CLR_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.cmd_clear && !stat.occ_zero) begin
                    state_next = ST_CLR_LOAD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_LOAD: begin
                cmd.clr_load = 1'b1;
                state_next   = ST_CLR_OUT;
            end
            ST_CLR_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.clr_shift = 1'b1;
                    state_next    = stat.occ_one ? ST_IDLE : ST_CLR_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lkhc_dp.sv]
// Datapath with the recency-ordered entry line, parallel key compare and result registers.
`default_nettype none
module lkhc_dp #(
    parameter int EVICT_LIMIT = lkhc_pkg::EVICT_LIMIT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lkhc_pkg::ctrl_cmd_t           cmd,
    output lkhc_pkg::ctrl_stat_t               stat,
    input  wire logic [lkhc_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [lkhc_pkg::DIM_W-1:0]    s_key_width,
    input  wire logic [lkhc_pkg::DIM_W-1:0]    s_key_height,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_scale_bits,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_aspect_bits,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_angle_bits,
    input  wire logic                          s_key_mirror,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_hardness_bits,
    input  wire logic [lkhc_pkg::HANDLE_W-1:0] s_new_handle,
    output logic                               m_hit,
    output logic [lkhc_pkg::HANDLE_W-1:0]      m_found_handle,
    output logic                               m_inserted,
    output logic                               m_released_valid,
    output logic [lkhc_pkg::HANDLE_W-1:0]      m_released_handle,
    output logic                               m_last
);
    import lkhc_pkg::*;

    localparam int DEPTH = EVICT_LIMIT + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [BITS_W-1:0]   scale;
        logic [BITS_W-1:0]   aspect;
        logic [BITS_W-1:0]   angle;
        logic [BITS_W-1:0]   hardness;
        logic                mirror;
    } entry_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found;
        logic                inserted;
        logic                rel_valid;
        logic [HANDLE_W-1:0] rel_handle;
        logic                last;
    } result_t;

    entry_t              entry_reg [DEPTH];
    entry_t              entry_next [DEPTH];
    entry_t              item_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [DEPTH-1:0]    key_match_reg;
    logic [DEPTH-1:0]    hdl_match_reg;
    result_t             res_reg;
    result_t             res_next;
    logic [IDX_W-1:0]    hit_idx;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg           <= s_cmd;
            item_reg.handle   <= s_new_handle;
            item_reg.height   <= s_key_height;
            item_reg.width    <= s_key_width;
            item_reg.scale    <= s_key_scale_bits;
            item_reg.aspect   <= s_key_aspect_bits;
            item_reg.angle    <= s_key_angle_bits;
            item_reg.hardness <= s_key_hardness_bits;
            item_reg.mirror   <= s_key_mirror;
        end
        if (cmd.cmp) begin
            for (int k = 0; k < DEPTH; k++) begin
                key_match_reg[k] <= (OCC_W'(k) < occ_reg)
                    && (entry_reg[k].handle != '0)
                    && (entry_reg[k].height == item_reg.height)
                    && (entry_reg[k].width == item_reg.width)
                    && (entry_reg[k].scale == item_reg.scale)
                    && (entry_reg[k].aspect == item_reg.aspect)
                    && (entry_reg[k].angle == item_reg.angle)
                    && (entry_reg[k].hardness == item_reg.hardness)
                    && (entry_reg[k].mirror == item_reg.mirror);
                hdl_match_reg[k] <= (OCC_W'(k) < occ_reg)
                    && (entry_reg[k].handle == item_reg.handle);
            end
        end
        entry_reg <= entry_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (key_match_reg[k]) begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        res_next   = res_reg;
        if (cmd.exec) begin
            res_next      = '0;
            res_next.last = 1'b1;
            case (cmd_reg)
                CMD_LOOKUP: begin
                    if (|key_match_reg) begin
                        res_next.hit   = 1'b1;
                        res_next.found = entry_reg[hit_idx].handle;
                        entry_next[0]  = entry_reg[hit_idx];
                        for (int k = 1; k < DEPTH; k++) begin
                            if (IDX_W'(k) <= hit_idx) begin
                                entry_next[k] = entry_reg[k-1];
                            end
                        end
                    end
                end
                CMD_ADD: begin
                    if ((item_reg.handle != '0) && !(|hdl_match_reg)) begin
                        res_next.inserted = 1'b1;
                        if (occ_reg == OCC_W'(DEPTH)) begin
                            res_next.rel_valid  = 1'b1;
                            res_next.rel_handle = entry_reg[DEPTH-1].handle;
                        end else begin
                            occ_next = occ_reg + 1'b1;
                        end
                        entry_next[0] = item_reg;
                        for (int k = 1; k < DEPTH; k++) begin
                            entry_next[k] = entry_reg[k-1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.clr_load) begin
            res_next            = '0;
            res_next.rel_valid  = 1'b1;
            res_next.rel_handle = entry_reg[0].handle;
            res_next.last       = (occ_reg == OCC_W'(1));
        end
        if (cmd.clr_shift) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                entry_next[k] = entry_reg[k+1];
            end
            occ_next = occ_reg - 1'b1;
        end
    end

    assign stat.cmd_clear = (cmd_reg == CMD_CLEAR);
    assign stat.occ_zero  = (occ_reg == '0);
    assign stat.occ_one   = (occ_reg == OCC_W'(1));

    assign m_hit             = res_reg.hit;
    assign m_found_handle    = res_reg.found;
    assign m_inserted        = res_reg.inserted;
    assign m_released_valid  = res_reg.rel_valid;
    assign m_released_handle = res_reg.rel_handle;
    assign m_last            = res_reg.last;

endmodule
`default_nettype wire

[rtl/lru_keyed_handle_cache.sv]
// Top level of the LRU keyed handle cache: controller and datapath.
`default_nettype none
// A fully associative cache of EVICT_LIMIT+1 entries kept in recency order, mapping
// a seven-part key to a nonzero 32-bit handle. One item is in work at a time. A
// lookup, add or unused command goes through acceptance, parallel compare of all
// entries into match registers, priority select and shift of the entry line, and
// result. Its result is offered in ST_OUT after states ST_CMP and ST_EXEC, and the
// next item can be accepted in the cycle after the result is taken. The result is
// held in ST_OUT while m_ready is low. A clear of N entries gives N results, each
// through ST_CLR_LOAD and ST_CLR_OUT, after the same acceptance, compare and
// select steps. Clearing an empty cache gives one result. No clear runs after reset.
module lru_keyed_handle_cache #(
    parameter int EVICT_LIMIT = lkhc_pkg::EVICT_LIMIT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lkhc_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [lkhc_pkg::DIM_W-1:0]    s_key_width,
    input  wire logic [lkhc_pkg::DIM_W-1:0]    s_key_height,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_scale_bits,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_aspect_bits,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_angle_bits,
    input  wire logic                          s_key_mirror,
    input  wire logic [lkhc_pkg::BITS_W-1:0]   s_key_hardness_bits,
    input  wire logic [lkhc_pkg::HANDLE_W-1:0] s_new_handle,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic [lkhc_pkg::HANDLE_W-1:0]      m_found_handle,
    output logic                               m_inserted,
    output logic                               m_released_valid,
    output logic [lkhc_pkg::HANDLE_W-1:0]      m_released_handle,
    output logic                               m_last
);
    import lkhc_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    lkhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lkhc_dp #(
        .EVICT_LIMIT (EVICT_LIMIT)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_cmd               (s_cmd),
        .s_key_width         (s_key_width),
        .s_key_height        (s_key_height),
        .s_key_scale_bits    (s_key_scale_bits),
        .s_key_aspect_bits   (s_key_aspect_bits),
        .s_key_angle_bits    (s_key_angle_bits),
        .s_key_mirror        (s_key_mirror),
        .s_key_hardness_bits (s_key_hardness_bits),
        .s_new_handle        (s_new_handle),
        .m_hit               (m_hit),
        .m_found_handle      (m_found_handle),
        .m_inserted          (m_inserted),
        .m_released_valid    (m_released_valid),
        .m_released_handle   (m_released_handle),
        .m_last              (m_last)
    );

endmodule
`default_nettype wire
